// ===== design/deque_with_positional_removal_assert.svh =====
// Assertion macros for the positional-removal deque.
// Uses clk and rst of the including module; no other dependencies.
`ifndef DEQUE_WITH_POSITIONAL_REMOVAL_ASSERT_SVH
`define DEQUE_WITH_POSITIONAL_REMOVAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DQ_ASSERT(lbl, prop, msg)
`define DQ_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/deq_pkg.sv =====
// Shared types and codes for the positional-removal deque.
// No dependencies.
package deq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REMOVE_AT  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOPOS = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_CAPT,
    S_MV_RD,
    S_MV_WR,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] removed;
    logic [1:0]         status;
    logic [4:0]         count;
  } res_t;

endpackage

// ===== design/deq_ram.sv =====
// Entry store of the deque: one write port, one read port with registered data.
// No package dependencies.
module deq_ram #(
  parameter int QUEUE_DEPTH = 16,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [31:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [31:0] rd_data
);

  logic signed [31:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/deq_ctrl.sv =====
// Sequencer of the deque: decodes a request, walks the entry store one move at
// a time through a shared pointer stepper. Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  logic [2:0]         operation,
  input  logic signed [31:0] data_value,
  input  logic [3:0]         position,
  input  logic               out_free,
  output logic               busy,
  output logic               res_valid,
  output res_t               res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic signed [31:0] mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic signed [31:0] mem_rdata
);

  localparam int PW = (CW > 4) ? CW : 4;
  localparam int XW = (CW > 5) ? CW : 5;

  state_t             state, state_next;
  logic [CW-1:0]      count;
  logic [AW-1:0]      ptr;
  logic               shift_down;
  logic signed [31:0] op_data;
  logic signed [31:0] removed;
  logic [1:0]         status;

  logic [AW-1:0] step;
  logic [CW-1:0] count_m1;
  logic [PW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          full, empty, nopos, ptr_more, step_more;

  // shared stepper: one position toward the front or the back
  assign step      = shift_down ? (ptr - AW'(1)) : (ptr + AW'(1));
  assign step_more = (CW'(step) + CW'(1)) < count;
  assign ptr_more  = (CW'(ptr) + CW'(1)) < count;
  assign count_m1  = count - CW'(1);
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign pos_x     = PW'(position);
  assign nopos     = pos_x >= PW'(count);
  assign cnt_x     = XW'(count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (operation)
            OP_PUSH_FRONT: state_next = full ? S_DONE : (empty ? S_PUT : S_MV_RD);
            OP_PUSH_BACK:  state_next = full ? S_DONE : S_PUT;
            OP_POP_FRONT,
            OP_POP_BACK:   state_next = empty ? S_DONE : S_TAKE;
            OP_REMOVE_AT:  state_next = (empty || nopos) ? S_DONE : S_TAKE;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_TAKE:  state_next = S_CAPT;
      S_CAPT:  state_next = ptr_more ? S_MV_RD : S_DONE;
      S_MV_RD: state_next = S_MV_WR;
      S_MV_WR: begin
        if (shift_down) begin
          state_next = (step == '0) ? S_PUT : S_MV_RD;
        end else begin
          state_next = step_more ? S_MV_RD : S_DONE;
        end
      end
      S_PUT:   state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != S_IDLE);
    res_valid   = (state == S_DONE);
    res.removed = removed;
    res.status  = status;
    res.count   = cnt_x[4:0];
    mem_we      = (state == S_MV_WR) || (state == S_PUT);
    mem_waddr   = ptr;
    mem_wdata   = (state == S_PUT) ? op_data : mem_rdata;
    mem_raddr   = (state == S_MV_RD) ? step : ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      // close the gap after the last move of a removal
      if ((state == S_CAPT && !ptr_more) ||
          (state == S_MV_WR && !shift_down && !step_more)) begin
        count <= count_m1;
      end else if (state == S_PUT) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          op_data    <= data_value;
          removed    <= '0;
          status     <= ST_OK;
          shift_down <= (operation == OP_PUSH_FRONT);
          ptr        <= AW'(count);
          case (operation)
            OP_PUSH_FRONT,
            OP_PUSH_BACK: begin
              if (full) status <= ST_FULL;
            end
            OP_POP_FRONT: begin
              ptr <= '0;
              if (empty) status <= ST_EMPTY;
            end
            OP_POP_BACK: begin
              ptr <= AW'(count_m1);
              if (empty) status <= ST_EMPTY;
            end
            OP_REMOVE_AT: begin
              ptr <= pos_x[AW-1:0];
              if (empty) begin
                status <= ST_EMPTY;
              end else if (nopos) begin
                status <= ST_NOPOS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CAPT:  removed <= mem_rdata;
      S_MV_WR: ptr <= step;
      default: begin
      end
    endcase
  end

endmodule

// ===== design/deque_with_positional_removal.sv =====
// Bounded double-ended queue of signed 32-bit words with removal by position.
// Input channel: in_valid/in_stall carry operation, data_value and position;
// a request is taken when in_valid is high and in_stall low. Output channel:
// out_valid/out_stall carry removed_value, status and item_count, one result
// per request, taken when out_valid is high and out_stall low.
// Requests are handled one at a time by a sequencer that moves one entry at a
// time through a single-port-write, registered-read entry store. A push back
// writes in S_PUT; a push front first shifts every entry one place back; a
// removal reads the entry in S_TAKE and S_CAPT, then shifts the entries behind
// it one place forward; a rejected request or unused code goes to S_DONE. The
// next request is taken in the cycle after the output register is loaded, at
// the earliest. in_stall is high from accept until the result is handed to the
// output register. While out_stall holds a result, the next request is still
// accepted and processed; it waits in its final state until the output
// register frees up. Reset clears the count and both channels; the entry store
// needs no clearing, as only entries below the count are read.
// Depends on deq_pkg, deq_ctrl, deq_ram and the assertion macro header.
`include "deque_with_positional_removal_assert.svh"

module deque_with_positional_removal import deq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [31:0] data_value,
  input  logic [3:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] removed_value,
  output logic [1:0]         status,
  output logic [4:0]         item_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [4:0] FULL_COUNT = 5'(QUEUE_DEPTH);

  logic               acc, busy, out_free, res_valid;
  res_t               res, out_res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [31:0] mem_wdata, mem_rdata;

  assign acc      = in_valid && !busy;
  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  deq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .operation  (operation),
    .data_value (data_value),
    .position   (position),
    .out_free   (out_free),
    .busy       (busy),
    .res_valid  (res_valid),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  deq_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res <= res;
    end
  end

  assign removed_value = out_res.removed;
  assign status        = out_res.status;
  assign item_count    = out_res.count;

  `DQ_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "no stall after accept")
  `DQ_NEVER(a_empty_count, out_valid && status == ST_EMPTY && item_count != '0, "count on empty")
  `DQ_NEVER(a_full_count, out_valid && status == ST_FULL && item_count != FULL_COUNT, "full count")
  `DQ_NEVER(a_fail_no_value, out_valid && status != ST_OK && removed_value != '0, "value on error")

endmodule

// ===== sim/deque_with_positional_removal_test.sv =====
// Self-checking testbench for the positional-removal deque: directed corner requests,
// then random push/pop phases with random input idle gaps and random output stalls.
// Depends on deq_pkg and the deque_with_positional_removal RTL.
module deque_with_positional_removal_test import deq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] OP_NOP_FIRST = 3'd5;
  localparam int MAX_REPORTS = 10;

  // Mirror of the deque contents and the results it must produce, oldest first.
  class deque_mirror;
    logic signed [31:0] words[DEPTH];
    int unsigned held;
    res_t pending[$];
    int unsigned mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    // Pull one entry out and close the gap behind it.
    function logic signed [31:0] take_at(int unsigned p);
      logic signed [31:0] word;
      word = words[p];
      for (int unsigned i = p; i + 1 < held; i++) words[i] = words[i + 1];
      held--;
      return word;
    endfunction

    function void apply_request(logic [2:0] op, logic signed [31:0] data, logic [3:0] pos);
      res_t want;
      want.removed = '0;
      want.status = ST_OK;
      case (op)
        OP_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            want.status = ST_FULL;
          end else begin
            for (int unsigned i = held; i > 0; i--) words[i] = words[i - 1];
            words[0] = data;
            held++;
          end
        end
        OP_PUSH_BACK: begin
          if (held >= DEPTH) begin
            want.status = ST_FULL;
          end else begin
            words[held] = data;
            held++;
          end
        end
        OP_POP_FRONT: begin
          if (held == 0) want.status = ST_EMPTY;
          else want.removed = take_at(0);
        end
        OP_POP_BACK: begin
          if (held == 0) want.status = ST_EMPTY;
          else want.removed = take_at(held - 1);
        end
        OP_REMOVE_AT: begin
          // empty wins over a bad position
          if (held == 0) want.status = ST_EMPTY;
          else if (pos >= held) want.status = ST_NOPOS;
          else want.removed = take_at(pos);
        end
        default: ;
      endcase
      want.count = 5'(held);
      pending.push_back(want);
    endfunction

    function void compare_result(logic signed [31:0] rv, logic [1:0] st, logic [4:0] cnt);
      res_t want;
      if (pending.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: removed %0d status %0d count %0d", rv, st, cnt);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (want.removed !== rv || want.status !== st || want.count !== cnt) begin
        if (mismatches < MAX_REPORTS)
          $display("mismatch: expected removed %0d status %0d count %0d, got %0d %0d %0d",
                   want.removed, want.status, want.count, rv, st, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         operation = '0;
  logic signed [31:0] data_value = '0;
  logic [3:0]         position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] removed_value;
  logic [1:0]         status;
  logic [4:0]         item_count;

  deque_mirror mirror = new();
  bit steady = 1'b0;
  int unsigned cycles = 0;

  deque_with_positional_removal #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .data_value(data_value),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .removed_value(removed_value),
    .status(status),
    .item_count(item_count)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("deque_with_positional_removal test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      mirror.compare_result(removed_value, status, item_count);
  end

  // Mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random output stalls; none while a steady stretch runs.
  initial begin : out_side
    int unsigned run;
    run = 0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_stall = 1'b0;
        run = 0;
      end else if (run > 0) begin
        run--;
      end else begin
        out_stall = ($urandom_range(0, 99) < 30);
        run = pick_gap();
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic signed [31:0] data,
                              input logic [3:0] pos);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    data_value = data;
    position = pos;
    do @(posedge clk); while (in_stall);
    mirror.apply_request(op, data, pos);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
  endtask

  // push_pct steers the fill level: high reaches full, low keeps hitting empty.
  task automatic run_phase(input int unsigned n, input int unsigned push_pct);
    int unsigned r;
    logic [2:0] op;
    logic [3:0] pos;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      pos = 4'($urandom_range(0, DEPTH - 1));
      if (r < 2) begin
        op = OP_NOP_FIRST + 3'($urandom_range(0, 2));
      end else if (r < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        case ($urandom_range(0, 2))
          0: op = OP_POP_FRONT;
          1: op = OP_POP_BACK;
          default: begin
            op = OP_REMOVE_AT;
            if (mirror.held > 0 && $urandom_range(0, 9) < 8)
              pos = 4'($urandom_range(0, mirror.held - 1));
          end
        endcase
      end
      send_request(op, pick_word(), pos);
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned len;
    int unsigned push_pct;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // removals on an empty deque, and an unused code
    send_request(OP_POP_FRONT, 32'sd1, 4'd0);
    send_request(OP_POP_BACK, 32'sd2, 4'd0);
    send_request(OP_REMOVE_AT, 32'sd3, 4'd15);
    send_request(OP_NOP_FIRST, 32'sd4, 4'd0);
    send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF, 4'd15);
    send_request(OP_PUSH_FRONT, 32'sh8000_0000, 4'd0);
    send_request(OP_PUSH_BACK, '1, 4'd0);
    send_request(OP_PUSH_FRONT, '0, 4'd0);
    // position at and past the count
    send_request(OP_REMOVE_AT, 32'sd5, 4'd4);
    send_request(OP_REMOVE_AT, 32'sd6, 4'd15);
    send_request(OP_REMOVE_AT, 32'sd7, 4'd1);
    send_request(OP_NOP_FIRST + 3'd2, 32'sd8, 4'd9);
    send_request(OP_POP_BACK, 32'sd9, 4'd0);
    send_request(OP_POP_FRONT, 32'sd10, 4'd0);
    send_request(OP_NOP_FIRST + 3'd1, 32'sh5A5A_A5A5, 4'd6);
    send_request(OP_REMOVE_AT, 32'sd11, 4'd0);
    send_request(OP_REMOVE_AT, 32'sd12, 4'd0);
    wait_drained();

    sent = 0;
    while (sent < 1700) begin
      len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 78;
        1: push_pct = 25;
        default: push_pct = 52;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      run_phase(len, push_pct);
      sent += len;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending.size() == 0) begin
      $display("deque_with_positional_removal test passed");
    end else begin
      $display("deque_with_positional_removal test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deque_with_positional_removal.sv
sim/deque_with_positional_removal_test.sv
